>>> rtl/core/dxt1_pkg.sv
// ----------------------------------------------------------------------------
// dxt1_pkg
// Shared types, constants and helpers of the BC1 block encoder.
// ----------------------------------------------------------------------------
package dxt1_pkg;

  // One RGBA pixel beat.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // One encoded block.
  typedef struct packed {
    logic [15:0] endpoint_zero;
    logic [15:0] endpoint_one;
    logic [31:0] index_bits;
  } result_t;

  // Per-channel extremes of the block being loaded.
  typedef struct packed {
    logic [7:0] r_lo;
    logic [7:0] g_lo;
    logic [7:0] b_lo;
    logic [7:0] r_hi;
    logic [7:0] g_hi;
    logic [7:0] b_hi;
    logic [7:0] a_lo;
    logic [7:0] a_hi;
  } ext_t;

  localparam int unsigned BLOCK_PIXELS = 16;
  localparam int unsigned ADDR_W       = $clog2(BLOCK_PIXELS);
  localparam logic [ADDR_W-1:0] LAST_PIXEL = ADDR_W'(BLOCK_PIXELS - 1);

  localparam logic [7:0] THRESH_RST = 8'd128;

  localparam ext_t EXT_RST = '{
    r_lo: 8'hff, g_lo: 8'hff, b_lo: 8'hff,
    r_hi: 8'h00, g_hi: 8'h00, b_hi: 8'h00,
    a_lo: 8'hff, a_hi: 8'h00
  };

  // Index codes.
  localparam logic [1:0] IDX_E0 = 2'd0;
  localparam logic [1:0] IDX_E1 = 2'd1;
  localparam logic [1:0] IDX_C2 = 2'd2;
  localparam logic [1:0] IDX_C3 = 2'd3;

  // Fixed pattern of a fully transparent block.
  localparam logic [15:0] TRANSP_E0   = 16'h0000;
  localparam logic [15:0] TRANSP_E1   = 16'hffff;
  localparam logic [31:0] TRANSP_BITS = 32'hffff_ffff;

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> rtl/core/dxt1_store.sv
// ----------------------------------------------------------------------------
// dxt1_store
// Pixel memory of one block: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dxt1_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [dxt1_pkg::ADDR_W-1:0] wr_addr,
  input  dxt1_pkg::pixel_t           wr_data,
  input  logic                       rd_en,
  input  logic [dxt1_pkg::ADDR_W-1:0] rd_addr,
  output dxt1_pkg::pixel_t           rd_data
);

  dxt1_pkg::pixel_t mem [dxt1_pkg::BLOCK_PIXELS];
  dxt1_pkg::pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/dxt1_collect.sv
// ----------------------------------------------------------------------------
// dxt1_collect
// Pixel counter and running channel extremes while a block loads.
// ----------------------------------------------------------------------------
module dxt1_collect (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  dxt1_pkg::pixel_t            pixel,
  input  logic [7:0]                  thresh,
  output logic                        wr_en,
  output logic [dxt1_pkg::ADDR_W-1:0] wr_addr,
  output dxt1_pkg::pixel_t            wr_data,
  output logic                        go,
  output dxt1_pkg::ext_t              ext_fin
);

  logic [dxt1_pkg::ADDR_W-1:0] count_r;
  dxt1_pkg::ext_t              ext_r;
  dxt1_pkg::ext_t              ext_nxt;
  logic                        opaque;

  always_comb begin
    opaque  = (pixel.alpha >= thresh);
    ext_nxt = ext_r;
    if (opaque) begin
      if (pixel.red   < ext_r.r_lo) ext_nxt.r_lo = pixel.red;
      if (pixel.green < ext_r.g_lo) ext_nxt.g_lo = pixel.green;
      if (pixel.blue  < ext_r.b_lo) ext_nxt.b_lo = pixel.blue;
      if (pixel.red   > ext_r.r_hi) ext_nxt.r_hi = pixel.red;
      if (pixel.green > ext_r.g_hi) ext_nxt.g_hi = pixel.green;
      if (pixel.blue  > ext_r.b_hi) ext_nxt.b_hi = pixel.blue;
    end
    if (pixel.alpha < ext_r.a_lo) ext_nxt.a_lo = pixel.alpha;
    if (pixel.alpha > ext_r.a_hi) ext_nxt.a_hi = pixel.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ext_r   <= dxt1_pkg::EXT_RST;
    end else if (accept) begin
      if (count_r == dxt1_pkg::LAST_PIXEL) begin
        count_r <= '0;
        ext_r   <= dxt1_pkg::EXT_RST;
      end else begin
        count_r <= count_r + 1'b1;
        ext_r   <= ext_nxt;
      end
    end
  end

  assign wr_en   = accept;
  assign wr_addr = count_r;
  assign wr_data = pixel;
  assign go      = accept && (count_r == dxt1_pkg::LAST_PIXEL);
  assign ext_fin = ext_nxt;

endmodule

>>> rtl/core/dxt1_quant.sv
// ----------------------------------------------------------------------------
// dxt1_quant
// Block quantizer: derives axis and length, scans the pixel memory and
// projects each pixel onto the axis to pick its 2-bit index.
// ----------------------------------------------------------------------------
module dxt1_quant (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  dxt1_pkg::ext_t              ext_fin,
  input  logic [7:0]                  thresh,
  output logic                        rd_en,
  output logic [dxt1_pkg::ADDR_W-1:0] rd_addr,
  input  dxt1_pkg::pixel_t            rd_data,
  output logic                        busy,
  output logic                        out_valid,
  output dxt1_pkg::result_t           out_result
);

  typedef enum logic [2:0] {Q_IDLE, Q_SETUP, Q_LEN, Q_SCAN, Q_DRAIN} qstate_t;

  qstate_t                     state_r;
  logic                        busy_r;
  logic                        out_valid_r;
  dxt1_pkg::result_t           out_result_r;

  dxt1_pkg::ext_t              ext_r;
  // Threshold in force at the last pixel of the block.
  logic [7:0]                  blk_thresh_r;
  logic signed [8:0]           vr_r, vg_r, vb_r;
  logic [17:0]                 len_r;
  logic                        transp_any_r;
  logic                        all_transp_r;
  logic [15:0]                 emax_r, emin_r;

  logic [dxt1_pkg::ADDR_W-1:0] rd_cnt_r;
  logic                        rd_vld_r;
  logic [dxt1_pkg::ADDR_W-1:0] rd_k_r;

  logic                        vld1_r;
  logic [dxt1_pkg::ADDR_W-1:0] k1_r;
  logic                        opq1_r;
  logic signed [17:0]          pr_r, pg_r, pb_r;

  logic [31:0]                 bits_r;
  logic [31:0]                 bits_nxt;

  // Squares of the axis for the length.
  logic signed [17:0]          sq_r, sq_g, sq_b;
  logic [17:0]                 len_sum;

  // Offsets of the pixel just read from the low corner.
  logic signed [8:0]           dr, dg, db;

  // Projection and index decision.
  logic signed [19:0]          dot;
  logic signed [25:0]          dx, lx;
  logic [1:0]                  idx;

  always_comb begin
    sq_r    = vr_r * vr_r;
    sq_g    = vg_r * vg_r;
    sq_b    = vb_r * vb_r;
    len_sum = 18'(sq_r[16:0]) + 18'(sq_g[16:0]) + 18'(sq_b[16:0]);
  end

  always_comb begin
    dr = $signed({1'b0, rd_data.red})   - $signed({1'b0, ext_r.r_lo});
    dg = $signed({1'b0, rd_data.green}) - $signed({1'b0, ext_r.g_lo});
    db = $signed({1'b0, rd_data.blue})  - $signed({1'b0, ext_r.b_lo});
  end

  always_comb begin
    dot = 20'(pr_r) + 20'(pg_r) + 20'(pb_r);
    dx  = 26'(dot);
    lx  = $signed({8'd0, len_r});
    if (transp_any_r) begin
      if (!opq1_r) begin
        idx = dxt1_pkg::IDX_C3;
      end else if (dx * 26'sd3 < lx) begin
        idx = dxt1_pkg::IDX_E0;
      end else if (dx * 26'sd3 < lx * 26'sd2) begin
        idx = dxt1_pkg::IDX_C2;
      end else begin
        idx = dxt1_pkg::IDX_E1;
      end
    end else begin
      if ((dx <<< 4) < lx * 26'sd3) begin
        idx = dxt1_pkg::IDX_E1;
      end else if ((dx <<< 1) < lx) begin
        idx = dxt1_pkg::IDX_C3;
      end else if ((dx <<< 4) < lx * 26'sd13) begin
        idx = dxt1_pkg::IDX_C2;
      end else begin
        idx = dxt1_pkg::IDX_E0;
      end
    end
    bits_nxt = bits_r;
    bits_nxt[{k1_r, 1'b0} +: 2] = idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= Q_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      vld1_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      vld1_r      <= rd_vld_r;

      if (rd_vld_r) begin
        k1_r   <= rd_k_r;
        opq1_r <= (rd_data.alpha >= blk_thresh_r);
        pr_r   <= dr * vr_r;
        pg_r   <= dg * vg_r;
        pb_r   <= db * vb_r;
      end
      if (vld1_r) begin
        bits_r <= bits_nxt;
      end

      unique case (state_r)
        Q_IDLE: begin
          if (go) begin
            ext_r        <= ext_fin;
            blk_thresh_r <= thresh;
            busy_r       <= 1'b1;
            state_r      <= Q_SETUP;
          end
        end
        Q_SETUP: begin
          vr_r         <= $signed({1'b0, ext_r.r_hi}) - $signed({1'b0, ext_r.r_lo});
          vg_r         <= $signed({1'b0, ext_r.g_hi}) - $signed({1'b0, ext_r.g_lo});
          vb_r         <= $signed({1'b0, ext_r.b_hi}) - $signed({1'b0, ext_r.b_lo});
          transp_any_r <= (ext_r.a_lo < blk_thresh_r);
          all_transp_r <= (ext_r.a_hi < blk_thresh_r);
          emax_r       <= dxt1_pkg::pack565(ext_r.r_hi, ext_r.g_hi, ext_r.b_hi);
          emin_r       <= dxt1_pkg::pack565(ext_r.r_lo, ext_r.g_lo, ext_r.b_lo);
          state_r      <= Q_LEN;
        end
        Q_LEN: begin
          // A flat axis in 3-color mode sends every opaque pixel to endpoint 0.
          if (transp_any_r && len_sum == '0) begin
            len_r <= 18'd3;
          end else begin
            len_r <= len_sum;
          end
          rd_cnt_r <= '0;
          state_r  <= Q_SCAN;
        end
        Q_SCAN: begin
          rd_vld_r <= 1'b1;
          rd_k_r   <= rd_cnt_r;
          rd_cnt_r <= rd_cnt_r + 1'b1;
          if (rd_cnt_r == dxt1_pkg::LAST_PIXEL) begin
            state_r <= Q_DRAIN;
          end
        end
        Q_DRAIN: begin
          if (vld1_r && k1_r == dxt1_pkg::LAST_PIXEL) begin
            out_valid_r <= 1'b1;
            busy_r      <= 1'b0;
            state_r     <= Q_IDLE;
            if (all_transp_r) begin
              out_result_r <= '{endpoint_zero: dxt1_pkg::TRANSP_E0,
                                endpoint_one:  dxt1_pkg::TRANSP_E1,
                                index_bits:    dxt1_pkg::TRANSP_BITS};
            end else if (transp_any_r) begin
              out_result_r <= '{endpoint_zero: emin_r, endpoint_one: emax_r,
                                index_bits: bits_nxt};
            end else if (len_r == '0 || emax_r == emin_r) begin
              out_result_r <= '{endpoint_zero: emax_r, endpoint_one: emin_r,
                                index_bits: '0};
            end else begin
              out_result_r <= '{endpoint_zero: emax_r, endpoint_one: emin_r,
                                index_bits: bits_nxt};
            end
          end
        end
        default: begin
          state_r <= Q_IDLE;
        end
      endcase
    end
  end

  assign rd_en      = (state_r == Q_SCAN);
  assign rd_addr    = rd_cnt_r;
  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

>>> rtl/core/dxt1_block_encoder.sv
// ----------------------------------------------------------------------------
// dxt1_block_encoder
// BC1 (DXT1) encoder for one 4x4 RGBA block at a time.
// ----------------------------------------------------------------------------
// Feed the 16 pixels of a block in row-major order, one beat per cycle while
// busy is low. The 16th beat raises busy while the quantizer sets up the
// color axis, scans the pixel memory through its single read port one entry
// per cycle and drains its two-stage projection pipe. The result appears on
// out_result for exactly one cycle with out_valid high, in the first cycle
// busy is low again; the receiver cannot stall it, so capture it then. The
// next block may start loading in that same cycle. The alpha threshold takes
// writes only while busy is low; change it between blocks.
// ----------------------------------------------------------------------------
module dxt1_block_encoder (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              start,
  output logic              busy,
  input  dxt1_pkg::pixel_t  in_pixel,
  // threshold register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  // encoded block
  output logic              out_valid,
  output dxt1_pkg::result_t out_result
);

  logic                        accept;
  logic [7:0]                  thresh_r;

  logic                        wr_en;
  logic [dxt1_pkg::ADDR_W-1:0] wr_addr;
  dxt1_pkg::pixel_t            wr_data;
  logic                        rd_en;
  logic [dxt1_pkg::ADDR_W-1:0] rd_addr;
  dxt1_pkg::pixel_t            rd_data;

  logic                        go;
  dxt1_pkg::ext_t              ext_fin;

  // Take a pixel beat only while the quantizer is idle.
  assign accept    = start && !busy;
  // Hold threshold writes off while a block is being quantized.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= dxt1_pkg::THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_data;
    end
  end

  // Count pixels, track extremes, write each pixel to its slot.
  dxt1_collect u_collect (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .pixel   (in_pixel),
    .thresh  (thresh_r),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .go      (go),
    .ext_fin (ext_fin)
  );

  // Block memory; writes and reads never overlap since loading stops while busy.
  dxt1_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Derive endpoints and indices from the stored block.
  dxt1_quant u_quant (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .ext_fin    (ext_fin),
    .thresh     (thresh_r),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // The last pixel of a block starts quantizing in the next cycle.
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy)
    else $error("busy did not rise after the last pixel of a block");

  // Results only come out of a quantizing pass.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding quantizing pass");

  // One strobe per block.
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // Interlock: no memory write while the scan reads the memory.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !busy && !rd_en)
    else $error("pixel memory written during a scan");

  // Threshold stays put through a quantizing pass.
  a_thresh_stable: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> $stable(thresh_r))
    else $error("threshold changed while quantizing");

endmodule

>>> dv/tb_dxt1_block_encoder.sv
// ----------------------------------------------------------------------------
// tb_dxt1_block_encoder
// Self-checking bench for the BC1 block encoder. A scoreboard class predicts
// every encoded block from the pixels it accepts and checks each result beat.
// Directed blocks hit the mode corners. Random blocks then run under several
// alpha thresholds, with bursty pixel traffic.
// ----------------------------------------------------------------------------
module tb_dxt1_block_encoder;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_LIMIT     = 4_000_000;  // time units, far above the slowest run

  // Predict encoded blocks and check the result beats against them.
  class bc1_scoreboard;
    logic [7:0]        threshold;
    dxt1_pkg::pixel_t  tile [16];
    int                fill;
    logic [7:0]        r_lo, g_lo, b_lo, r_hi, g_hi, b_hi, a_lo, a_hi;
    dxt1_pkg::result_t due [$];
    int                errors, blocks_done, opaque_blocks, cutout_blocks, clear_blocks;

    function new();
      threshold = dxt1_pkg::THRESH_RST;
      fill      = 0;
      clear_extremes();
    endfunction

    function void clear_extremes();
      r_lo = 8'hff; g_lo = 8'hff; b_lo = 8'hff; a_lo = 8'hff;
      r_hi = 8'h00; g_hi = 8'h00; b_hi = 8'h00; a_hi = 8'h00;
    endfunction

    function void set_threshold(logic [7:0] value);
      threshold = value;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function logic [15:0] to_rgb565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [15:0] r16, g16, b16;
      r16 = 16'(r);
      g16 = 16'(g);
      b16 = 16'(b);
      return ((r16 >> 3) << 11) | ((g16 >> 2) << 5) | (b16 >> 3);
    endfunction

    // Dot product of (pixel - min) with the color axis.
    function int project(dxt1_pkg::pixel_t px, int vr, int vg, int vb);
      return (int'(px.red) - int'(r_lo)) * vr + (int'(px.green) - int'(g_lo)) * vg +
             (int'(px.blue) - int'(b_lo)) * vb;
    endfunction

    function void close_block();
      int                vr, vg, vb, len, d;
      logic [15:0]       e0, e1;
      logic [31:0]       bits;
      logic [1:0]        idx;
      dxt1_pkg::result_t res;
      vr   = int'(r_hi) - int'(r_lo);
      vg   = int'(g_hi) - int'(g_lo);
      vb   = int'(b_hi) - int'(b_lo);
      len  = vr * vr + vg * vg + vb * vb;
      bits = '0;
      if (a_lo < threshold) begin
        if (a_hi < threshold) begin
          e0 = dxt1_pkg::TRANSP_E0;
          e1 = dxt1_pkg::TRANSP_E1;
          bits = dxt1_pkg::TRANSP_BITS;
          clear_blocks++;
        end else begin
          // three-color mode: min first, transparent pixels take code 3
          e0 = to_rgb565(r_lo, g_lo, b_lo);
          e1 = to_rgb565(r_hi, g_hi, b_hi);
          if (len == 0) len = 3;
          for (int k = 0; k < 16; k++) begin
            if (tile[k].alpha >= threshold) begin
              d = 3 * project(tile[k], vr, vg, vb);
              if (d < len) idx = dxt1_pkg::IDX_E0;
              else if (d < 2 * len) idx = dxt1_pkg::IDX_C2;
              else idx = dxt1_pkg::IDX_E1;
            end else begin
              idx = dxt1_pkg::IDX_C3;
            end
            bits[2*k +: 2] = idx;
          end
          cutout_blocks++;
        end
      end else begin
        e0 = to_rgb565(r_hi, g_hi, b_hi);
        e1 = to_rgb565(r_lo, g_lo, b_lo);
        // a flat block or equal endpoints keeps all indexes at zero
        if (len > 0 && e0 != e1) begin
          for (int k = 0; k < 16; k++) begin
            d = project(tile[k], vr, vg, vb);
            if (16 * d < 3 * len) idx = dxt1_pkg::IDX_E1;
            else if (2 * d < len) idx = dxt1_pkg::IDX_C3;
            else if (16 * d < 13 * len) idx = dxt1_pkg::IDX_C2;
            else idx = dxt1_pkg::IDX_E0;
            bits[2*k +: 2] = idx;
          end
        end
        opaque_blocks++;
      end
      res.endpoint_zero = e0;
      res.endpoint_one  = e1;
      res.index_bits    = bits;
      due.push_back(res);
    endfunction

    function void note_pixel(dxt1_pkg::pixel_t px);
      tile[fill] = px;
      if (px.alpha >= threshold) begin
        if (px.red < r_lo) r_lo = px.red;
        if (px.green < g_lo) g_lo = px.green;
        if (px.blue < b_lo) b_lo = px.blue;
        if (px.red > r_hi) r_hi = px.red;
        if (px.green > g_hi) g_hi = px.green;
        if (px.blue > b_hi) b_hi = px.blue;
      end
      if (px.alpha < a_lo) a_lo = px.alpha;
      if (px.alpha > a_hi) a_hi = px.alpha;
      if (fill == 15) begin
        close_block();
        fill = 0;
        clear_extremes();
      end else begin
        fill++;
      end
    endfunction

    task log_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at block %0d, %s: got %h, want %h", blocks_done, what, got, want);
      errors++;
    endtask

    task check_block(dxt1_pkg::result_t got);
      dxt1_pkg::result_t want;
      if (due.size() == 0) begin
        log_mismatch("result beat with no block pending", got.index_bits, '0);
        return;
      end
      want = due.pop_front();
      blocks_done++;
      if (got.endpoint_zero !== want.endpoint_zero)
        log_mismatch("endpoint_zero", 32'(got.endpoint_zero), 32'(want.endpoint_zero));
      if (got.endpoint_one !== want.endpoint_one)
        log_mismatch("endpoint_one", 32'(got.endpoint_one), 32'(want.endpoint_one));
      if (got.index_bits !== want.index_bits)
        log_mismatch("index_bits", got.index_bits, want.index_bits);
    endtask
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  dxt1_pkg::pixel_t  in_pixel  = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data  = '0;
  logic              out_valid;
  dxt1_pkg::result_t out_result;

  bc1_scoreboard sb = new();
  int burst_left    = 0;
  int pixels_sent   = 0;
  int thresh_writes = 0;

  dxt1_block_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #HALF_PERIOD clk = ~clk;

  // Capture every result beat; the block cannot be held off, so sample each cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_block(out_result);
  end

  function automatic dxt1_pkg::pixel_t rgba(int r, int g, int b, int a);
    dxt1_pkg::pixel_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    px.alpha = 8'(a);
    return px;
  endfunction

  // Send one pixel beat. Open a new burst when the old one runs out, with a
  // random gap in front of it; hold start high across back-to-back beats.
  task automatic push_pixel(input dxt1_pkg::pixel_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start    <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (busy);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  // Drop start, wait for every pending block to come out, then let the
  // quantizer drain completely.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_threshold(value);
    thresh_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int spread, lo_r, lo_g, lo_b, alpha_style, a, thr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed blocks, threshold at its reset value ----
    // Gradient, all opaque: four-color mode with a real axis.
    for (int k = 0; k < 16; k++) push_pixel(rgba(k * 17, 255 - k * 17, k * 9, 255));
    // One flat color: zero axis length, indexes stay zero.
    for (int k = 0; k < 16; k++) push_pixel(rgba(200, 100, 50, 255));
    // Colors that differ only below the 565 step: equal endpoints.
    for (int k = 0; k < 16; k++)
      push_pixel(rgba(8'h40 | (k & 7), 8'h80 | (k & 3), 8'h10 | ((k >> 1) & 7), 255));
    // Black and white, alpha exactly at the threshold still counts as opaque.
    for (int k = 0; k < 16; k++)
      push_pixel((k % 2 == 0) ? rgba(0, 0, 0, 255) : rgba(255, 255, 255, 128));
    // Alpha one below the threshold on odd pixels: three-color mode.
    for (int k = 0; k < 16; k++)
      push_pixel(rgba($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), (k % 2 == 1) ? 127 : 255));
    // Partly transparent over one flat color: forced axis length.
    for (int k = 0; k < 16; k++) push_pixel(rgba(90, 180, 45, (k % 3 == 0) ? 0 : 200));
    // Every alpha below the threshold: fixed transparent pattern.
    for (int k = 0; k < 16; k++)
      push_pixel(rgba($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), k * 8));

    // Threshold zero: nothing can be transparent.
    settle();
    write_threshold(8'h00);
    for (int k = 0; k < 16; k++)
      push_pixel(rgba($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), (k == 5) ? 0 : $urandom_range(0, 255)));

    // Threshold at full scale: mixed, then fully transparent at 254.
    settle();
    write_threshold(8'hff);
    for (int k = 0; k < 16; k++)
      push_pixel(rgba(k * 16, 255 - k * 3, k * 11, (k % 4 == 0) ? 254 : 255));
    for (int k = 0; k < 16; k++) push_pixel(rgba(255, 0, 255, 254));

    // Raise opacity halfway through a block: early pixels keep out of the
    // extremes, the mode is decided with the new threshold.
    for (int k = 0; k < 8; k++) push_pixel(rgba(k * 30, 40, 255 - k * 30, 200));
    settle();
    write_threshold(8'd100);
    for (int k = 8; k < 16; k++) push_pixel(rgba(k * 10, 250 - k * 5, 7, 200));

    // Drop opacity halfway: extremes from both halves, mode from the new threshold.
    settle();
    write_threshold(8'h00);
    for (int k = 0; k < 8; k++) push_pixel(rgba(255 - k * 20, k * 25, 128, 50));
    settle();
    write_threshold(8'd200);
    for (int k = 8; k < 16; k++) push_pixel(rgba(k * 5, 60, k * 15, 250));

    // ---- random blocks, one threshold per phase ----
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0:       thr = int'(dxt1_pkg::THRESH_RST);
        1:       thr = 0;
        2:       thr = 255;
        default: thr = $urandom_range(1, 254);
      endcase
      write_threshold(8'(thr));
      for (int blk = 0; blk < 16; blk++) begin
        // Pick a color spread: flat, narrow (likely equal endpoints) or wide.
        case ($urandom_range(0, 3))
          0:       spread = 0;
          1:       spread = $urandom_range(0, 7);
          default: spread = $urandom_range(0, 255);
        endcase
        lo_r = $urandom_range(0, 255 - spread);
        lo_g = $urandom_range(0, 255 - spread);
        lo_b = $urandom_range(0, 255 - spread);
        alpha_style = $urandom_range(0, 5);
        for (int k = 0; k < 16; k++) begin
          case (alpha_style)
            0, 1, 2: a = $urandom_range(thr, 255);
            3:       a = ($urandom_range(0, 3) == 0 && thr > 0) ? $urandom_range(0, thr - 1)
                                                                : $urandom_range(thr, 255);
            4:       a = (thr > 0) ? $urandom_range(0, thr - 1) : 0;
            default: a = $urandom_range(0, 255);
          endcase
          push_pixel(rgba($urandom_range(lo_r, lo_r + spread), $urandom_range(lo_g, lo_g + spread),
                          $urandom_range(lo_b, lo_b + spread), a));
        end
      end
    end

    // Drain and decide.
    settle();
    $display("covered %0d pixels and %0d threshold writes; checked %0d blocks", pixels_sent,
             thresh_writes, sb.blocks_done);
    $display("blocks by mode: %0d opaque, %0d cut-out, %0d fully transparent",
             sb.opaque_blocks, sb.cutout_blocks, sb.clear_blocks);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dxt1_block_encoder regression: pass");
    end else begin
      $display("dxt1_block_encoder regression: fail");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #RUN_LIMIT;
    $display("dxt1_block_encoder regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/dxt1_pkg.sv
rtl/core/dxt1_store.sv
rtl/core/dxt1_collect.sv
rtl/core/dxt1_quant.sv
rtl/core/dxt1_block_encoder.sv
dv/tb_dxt1_block_encoder.sv
